// File: rtl/sdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_pkg: shared types and constants of the SD SPI-mode init sequencer
// Phase, status, card type and command codes, plus the R1 error decoder.
// ----------------------------------------------------------------------------
package sdi_pkg;

    // Sequence phase: which command's answer is expected next
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_CMD55  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD1   = 4'd5,
        PH_CMD58  = 4'd6,
        PH_CMD16  = 4'd7,
        PH_CMD9   = 4'd8
    } phase_t;

    // Completion status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_CARD     = 3'd1,
        ST_NO_RESPONSE = 3'd2,
        ST_CRC         = 3'd3,
        ST_ERASE       = 3'd4,
        ST_PARAM       = 3'd5,
        ST_UNSUPPORTED = 3'd6,
        ST_TRANSPORT   = 3'd7
    } status_t;

    // Card types
    typedef enum logic [2:0] {
        CARD_UNKNOWN  = 3'd0,
        CARD_SD_V1    = 3'd1,
        CARD_SD_V2_SC = 3'd2,
        CARD_SD_V2_HC = 3'd3,
        CARD_MMC_V3   = 3'd4
    } card_t;

    // Action chosen for one accepted item
    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_DONE      = 4'd1,
        ACT_CMD0      = 4'd2,
        ACT_CMD8      = 4'd3,
        ACT_CMD55     = 4'd4,
        ACT_CMD55_WT  = 4'd5,
        ACT_ACMD41    = 4'd6,
        ACT_CMD1      = 4'd7,
        ACT_CMD1_WT   = 4'd8,
        ACT_CMD58     = 4'd9,
        ACT_CMD16     = 4'd10,
        ACT_CMD9      = 4'd11,
        ACT_CSD       = 4'd12
    } act_t;

    // CSD decode result passed to the top level
    typedef struct packed {
        logic        ok;
        logic [32:0] count;
    } csd_info_t;

    // Input operation codes
    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // Expected response kinds
    localparam logic [1:0] RESP_R1 = 2'd0;
    localparam logic [1:0] RESP_R2 = 2'd1;
    localparam logic [1:0] RESP_R3 = 2'd2;
    localparam logic [1:0] RESP_R7 = 2'd3;

    // Pre-send wait codes
    localparam logic [1:0] WAIT_NONE     = 2'd0;
    localparam logic [1:0] WAIT_1MS      = 2'd1;
    localparam logic [1:0] WAIT_POWER_UP = 2'd2;

    // Command numbers
    localparam logic [5:0] CMD_GO_IDLE     = 6'd0;
    localparam logic [5:0] CMD_SEND_OP     = 6'd1;
    localparam logic [5:0] CMD_SEND_IF     = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD    = 6'd9;
    localparam logic [5:0] CMD_SET_BLKLEN  = 6'd16;
    localparam logic [5:0] CMD_APP_OP      = 6'd41;
    localparam logic [5:0] CMD_APP_CMD     = 6'd55;
    localparam logic [5:0] CMD_READ_OCR    = 6'd58;

    // Block geometry and ACMD41 HCS bit
    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_RETRY_LIMIT   = 2'd0;
    localparam logic [1:0]  CFG_VOLTAGE_CODE  = 2'd1;
    localparam logic [1:0]  CFG_CHECK_PATTERN = 2'd2;
    localparam logic [15:0] RETRY_LIMIT_RST   = 16'd1000;
    localparam logic [3:0]  VOLTAGE_CODE_RST  = 4'd1;
    localparam logic [7:0]  CHECK_PATTERN_RST = 8'hAA;

    // Map R1 error bits to a status by priority
    function automatic status_t r1_status(input logic [7:0] r1);
        status_t s;
        if (r1[3])
            s = ST_CRC;
        else if (r1[1] || r1[4])
            s = ST_ERASE;
        else if (r1[5] || r1[6])
            s = ST_PARAM;
        else if (r1[2])
            s = ST_UNSUPPORTED;
        else
            s = ST_OK;
        return s;
    endfunction

endpackage

// File: rtl/sdi_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_channels: valid/ready channels of the init sequencer
// Request channel (start or card response) and result channel.
// ----------------------------------------------------------------------------
interface sdi_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        card_absent;
    logic        link_failed;
    logic [7:0]  resp_r1;
    logic [31:0] resp_payload;
    logic [63:0] csd_upper;
    logic [63:0] csd_lower;

    modport source (
        output valid, op, card_absent, link_failed, resp_r1, resp_payload,
               csd_upper, csd_lower,
        input  ready
    );
    modport sink (
        input  valid, op, card_absent, link_failed, resp_r1, resp_payload,
               csd_upper, csd_lower,
        output ready
    );
endinterface

interface sdi_out_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_kind;
    logic [1:0]  pre_wait;
    logic [2:0]  status;
    logic [2:0]  card_type;
    logic [32:0] block_count;

    modport source (
        output valid, done_res, cmd_index, cmd_arg, resp_kind, pre_wait, status,
               card_type, block_count,
        input  ready
    );
    modport sink (
        input  valid, done_res, cmd_index, cmd_arg, resp_kind, pre_wait, status,
               card_type, block_count,
        output ready
    );
endinterface

// File: rtl/sdi_csd_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_csd_calc: CSD structure check and capacity decode
// Checks the CSD structure against the card type and computes 512-byte blocks.
// ----------------------------------------------------------------------------
module sdi_csd_calc (
    input  logic [63:0]        csd_upper,
    input  logic [63:0]        csd_lower,
    input  sdi_pkg::card_t     card_kind,
    output sdi_pkg::csd_info_t info
);

    logic [1:0]  csd_ver;
    logic        legacy;
    logic        supported;
    logic [11:0] c_size;
    logic [12:0] c_size_p1;
    logic [2:0]  c_size_mult;
    logic [3:0]  read_bl_len;
    logic [4:0]  shamt;
    logic [36:0] legacy_bytes;
    logic [21:0] hc_size;
    logic [22:0] hc_size_p1;

    assign csd_ver = csd_upper[63:62];

    // Match structure version against the card type
    always_comb
    begin
        legacy    = 1'b0;
        supported = 1'b0;
        if (card_kind == sdi_pkg::CARD_MMC_V3 && !csd_ver[1])
        begin
            legacy    = 1'b1;
            supported = 1'b1;
        end
        else if (csd_ver == 2'd0 && (card_kind == sdi_pkg::CARD_SD_V1 ||
                                     card_kind == sdi_pkg::CARD_SD_V2_SC))
        begin
            legacy    = 1'b1;
            supported = 1'b1;
        end
        else if (csd_ver == 2'd1 && card_kind == sdi_pkg::CARD_SD_V2_HC)
        begin
            supported = 1'b1;
        end
    end

    // Standard capacity: (C_SIZE+1) << (C_SIZE_MULT+2+READ_BL_LEN) bytes
    assign c_size       = {csd_upper[9:0], csd_lower[63:62]};
    assign c_size_p1    = {1'b0, c_size} + 13'd1;
    assign c_size_mult  = csd_lower[49:47];
    assign read_bl_len  = csd_upper[19:16];
    assign shamt        = {2'b00, c_size_mult} + {1'b0, read_bl_len} + 5'd2;
    assign legacy_bytes = {24'd0, c_size_p1} << shamt;

    // High capacity: (C_SIZE+1) * 1024 blocks
    assign hc_size    = {csd_upper[5:0], csd_lower[63:48]};
    assign hc_size_p1 = {1'b0, hc_size} + 23'd1;

    // Select the count for the accepted structure
    always_comb
    begin
        info.ok = supported;
        if (!supported)
            info.count = '0;
        else if (legacy)
            info.count = 33'(legacy_bytes >> sdi_pkg::BLOCK_SHIFT);
        else
            info.count = {hc_size_p1, 10'd0};
    end

endmodule

// File: rtl/sd_spi_card_init_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_card_init_sequencer: SD SPI-mode identification sequencer
// Turns start requests and card responses into the next command or a done
// result with status, card type and block count.
// ----------------------------------------------------------------------------
// An accepted item's result is registered in the output register.
// Throughput: 1 item per cycle while results are drained; the one-entry output register is refilled in
// the same cycle it is drained, so input ready is low only while a result waits.
// A response that arrives while idle produces no result.
// Reset: phase idle, attempt count zero, card type unknown, output empty,
// retry_limit 1000, voltage_code 1, check_pattern 0xAA.
module sd_spi_card_init_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    sdi_in_if.sink      in_ch,
    sdi_out_if.source   out_ch
);

    // Configuration registers
    logic [15:0] retry_limit_reg;
    logic [3:0]  voltage_code_reg;
    logic [7:0]  check_pattern_reg;

    // Sequencer state
    sdi_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     attempts_reg, attempts_next;
    sdi_pkg::card_t  card_kind_reg, card_kind_next;
    logic            hcr_reg, hcr_next;

    // Output register
    logic            out_valid_reg;
    logic            done_res_reg, done_res_next;
    logic [5:0]      cmd_index_reg, cmd_index_next;
    logic [31:0]     cmd_arg_reg, cmd_arg_next;
    logic [1:0]      resp_kind_reg, resp_kind_next;
    logic [1:0]      pre_wait_reg, pre_wait_next;
    logic [2:0]      status_reg, status_next;
    logic [2:0]      card_type_reg, card_type_next;
    logic [32:0]     block_count_reg, block_count_next;

    logic               accept;
    sdi_pkg::act_t      act;
    sdi_pkg::status_t   done_status;
    sdi_pkg::status_t   r1_stat;
    logic [11:0]        cond;
    logic [15:0]        attempts_inc;
    logic               retry_ok;
    sdi_pkg::csd_info_t csd_info;

    // Take an item whenever the output slot is free or being drained
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;
    assign r1_stat      = sdi_pkg::r1_status(in_ch.resp_r1);
    assign cond         = {voltage_code_reg, check_pattern_reg};
    assign attempts_inc = attempts_reg + 16'd1;
    assign retry_ok     = attempts_inc < retry_limit_reg;

    sdi_csd_calc u_csd (
        .csd_upper (in_ch.csd_upper),
        .csd_lower (in_ch.csd_lower),
        .card_kind (card_kind_reg),
        .info      (csd_info)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= sdi_pkg::RETRY_LIMIT_RST;
            voltage_code_reg  <= sdi_pkg::VOLTAGE_CODE_RST;
            check_pattern_reg <= sdi_pkg::CHECK_PATTERN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdi_pkg::CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_wdata;
                sdi_pkg::CFG_VOLTAGE_CODE:  voltage_code_reg  <= cfg_wdata[3:0];
                sdi_pkg::CFG_CHECK_PATTERN: check_pattern_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Next state: pick the action for the accepted item and advance the phase
    always_comb
    begin
        phase_next     = phase_reg;
        attempts_next  = attempts_reg;
        card_kind_next = card_kind_reg;
        hcr_next       = hcr_reg;
        act            = sdi_pkg::ACT_NONE;
        done_status    = sdi_pkg::ST_OK;
        if (accept)
        begin
            if (in_ch.op == sdi_pkg::OP_START)
            begin
                attempts_next  = '0;
                card_kind_next = sdi_pkg::CARD_UNKNOWN;
                hcr_next       = 1'b0;
                if (in_ch.card_absent)
                begin
                    act         = sdi_pkg::ACT_DONE;
                    done_status = sdi_pkg::ST_NO_CARD;
                end
                else
                begin
                    act        = sdi_pkg::ACT_CMD0;
                    phase_next = sdi_pkg::PH_CMD0;
                end
            end
            else
            begin
                case (phase_reg)
                    sdi_pkg::PH_IDLE: ;
                    sdi_pkg::PH_CMD0:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else if (!in_ch.resp_r1[0])
                            done_status = sdi_pkg::ST_UNSUPPORTED;
                        else
                        begin
                            act        = sdi_pkg::ACT_CMD8;
                            phase_next = sdi_pkg::PH_CMD8;
                        end
                    end
                    sdi_pkg::PH_CMD8:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (in_ch.resp_r1[2] && r1_stat != sdi_pkg::ST_UNSUPPORTED)
                            done_status = r1_stat;
                        else if (!in_ch.resp_r1[2] && r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else if (!in_ch.resp_r1[2] &&
                                 in_ch.resp_payload[15:0] != {4'd0, cond})
                            done_status = sdi_pkg::ST_UNSUPPORTED;
                        else
                        begin
                            // Illegal CMD8 means v1; a good echo means v2
                            hcr_next      = !in_ch.resp_r1[2];
                            attempts_next = '0;
                            act           = sdi_pkg::ACT_CMD55;
                            phase_next    = sdi_pkg::PH_CMD55;
                        end
                    end
                    sdi_pkg::PH_CMD55, sdi_pkg::PH_ACMD41:
                    begin
                        if (in_ch.link_failed || r1_stat != sdi_pkg::ST_OK)
                            done_status = in_ch.link_failed ? sdi_pkg::ST_TRANSPORT
                                                            : r1_stat;
                        else if (phase_reg == sdi_pkg::PH_CMD55)
                        begin
                            act        = sdi_pkg::ACT_ACMD41;
                            phase_next = sdi_pkg::PH_ACMD41;
                        end
                        else if (!in_ch.resp_r1[0])
                        begin
                            if (hcr_reg)
                            begin
                                act        = sdi_pkg::ACT_CMD58;
                                phase_next = sdi_pkg::PH_CMD58;
                            end
                            else
                            begin
                                card_kind_next = sdi_pkg::CARD_SD_V1;
                                act            = sdi_pkg::ACT_CMD16;
                                phase_next     = sdi_pkg::PH_CMD16;
                            end
                        end
                        else
                        begin
                            attempts_next = attempts_inc;
                            if (retry_ok)
                            begin
                                act        = sdi_pkg::ACT_CMD55_WT;
                                phase_next = sdi_pkg::PH_CMD55;
                            end
                            else
                                done_status = sdi_pkg::ST_NO_RESPONSE;
                        end
                        // Loop failure: v2 ends here, v1 falls back to CMD1
                        if (act == sdi_pkg::ACT_NONE)
                        begin
                            if (hcr_reg)
                                act = sdi_pkg::ACT_DONE;
                            else
                            begin
                                attempts_next = '0;
                                act           = sdi_pkg::ACT_CMD1;
                                phase_next    = sdi_pkg::PH_CMD1;
                            end
                        end
                    end
                    sdi_pkg::PH_CMD1:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else if (!in_ch.resp_r1[0])
                        begin
                            card_kind_next = sdi_pkg::CARD_MMC_V3;
                            act            = sdi_pkg::ACT_CMD16;
                            phase_next     = sdi_pkg::PH_CMD16;
                        end
                        else
                        begin
                            attempts_next = attempts_inc;
                            if (retry_ok)
                                act = sdi_pkg::ACT_CMD1_WT;
                            else
                                done_status = sdi_pkg::ST_NO_RESPONSE;
                        end
                    end
                    sdi_pkg::PH_CMD58:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else if (in_ch.resp_payload[30])
                        begin
                            card_kind_next = sdi_pkg::CARD_SD_V2_HC;
                            act            = sdi_pkg::ACT_CMD9;
                            phase_next     = sdi_pkg::PH_CMD9;
                        end
                        else
                        begin
                            card_kind_next = sdi_pkg::CARD_SD_V2_SC;
                            act            = sdi_pkg::ACT_CMD16;
                            phase_next     = sdi_pkg::PH_CMD16;
                        end
                    end
                    sdi_pkg::PH_CMD16:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else
                        begin
                            act        = sdi_pkg::ACT_CMD9;
                            phase_next = sdi_pkg::PH_CMD9;
                        end
                    end
                    sdi_pkg::PH_CMD9:
                    begin
                        act = sdi_pkg::ACT_DONE;
                        if (in_ch.link_failed)
                            done_status = sdi_pkg::ST_TRANSPORT;
                        else if (r1_stat != sdi_pkg::ST_OK)
                            done_status = r1_stat;
                        else
                        begin
                            act         = sdi_pkg::ACT_CSD;
                            done_status = csd_info.ok ? sdi_pkg::ST_OK
                                                      : sdi_pkg::ST_UNSUPPORTED;
                        end
                    end
                    default: ;
                endcase
            end
            // Any completion returns to idle
            if (act == sdi_pkg::ACT_DONE || act == sdi_pkg::ACT_CSD)
                phase_next = sdi_pkg::PH_IDLE;
        end
    end

    // Outputs: build the result item for the chosen action
    always_comb
    begin
        done_res_next    = 1'b0;
        cmd_index_next   = sdi_pkg::CMD_GO_IDLE;
        cmd_arg_next     = '0;
        resp_kind_next   = sdi_pkg::RESP_R1;
        pre_wait_next    = sdi_pkg::WAIT_NONE;
        status_next      = sdi_pkg::ST_OK;
        card_type_next   = sdi_pkg::CARD_UNKNOWN;
        block_count_next = '0;
        case (act)
            sdi_pkg::ACT_DONE, sdi_pkg::ACT_CSD:
            begin
                done_res_next  = 1'b1;
                status_next    = done_status;
                card_type_next = card_kind_next;
                if (act == sdi_pkg::ACT_CSD)
                    block_count_next = csd_info.count;
            end
            sdi_pkg::ACT_CMD0:
                pre_wait_next = sdi_pkg::WAIT_POWER_UP;
            sdi_pkg::ACT_CMD8:
            begin
                cmd_index_next = sdi_pkg::CMD_SEND_IF;
                cmd_arg_next   = {20'd0, cond};
                resp_kind_next = sdi_pkg::RESP_R7;
            end
            sdi_pkg::ACT_CMD55:
                cmd_index_next = sdi_pkg::CMD_APP_CMD;
            sdi_pkg::ACT_CMD55_WT:
            begin
                cmd_index_next = sdi_pkg::CMD_APP_CMD;
                pre_wait_next  = sdi_pkg::WAIT_1MS;
            end
            sdi_pkg::ACT_ACMD41:
            begin
                cmd_index_next = sdi_pkg::CMD_APP_OP;
                cmd_arg_next   = hcr_reg ? sdi_pkg::ARG_HCS : 32'd0;
            end
            sdi_pkg::ACT_CMD1:
                cmd_index_next = sdi_pkg::CMD_SEND_OP;
            sdi_pkg::ACT_CMD1_WT:
            begin
                cmd_index_next = sdi_pkg::CMD_SEND_OP;
                pre_wait_next  = sdi_pkg::WAIT_1MS;
            end
            sdi_pkg::ACT_CMD58:
            begin
                cmd_index_next = sdi_pkg::CMD_READ_OCR;
                resp_kind_next = sdi_pkg::RESP_R3;
            end
            sdi_pkg::ACT_CMD16:
            begin
                cmd_index_next = sdi_pkg::CMD_SET_BLKLEN;
                cmd_arg_next   = 32'(sdi_pkg::BLOCK_BYTES);
            end
            sdi_pkg::ACT_CMD9:
            begin
                cmd_index_next = sdi_pkg::CMD_SEND_CSD;
                resp_kind_next = sdi_pkg::RESP_R2;
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sdi_pkg::PH_IDLE;
            attempts_reg  <= '0;
            card_kind_reg <= sdi_pkg::CARD_UNKNOWN;
            hcr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            attempts_reg  <= attempts_next;
            card_kind_reg <= card_kind_next;
            hcr_reg       <= hcr_next;
            if (act != sdi_pkg::ACT_NONE)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load with each new item
    always_ff @(posedge clk)
    begin
        if (act != sdi_pkg::ACT_NONE)
        begin
            done_res_reg    <= done_res_next;
            cmd_index_reg   <= cmd_index_next;
            cmd_arg_reg     <= cmd_arg_next;
            resp_kind_reg   <= resp_kind_next;
            pre_wait_reg    <= pre_wait_next;
            status_reg      <= status_next;
            card_type_reg   <= card_type_next;
            block_count_reg <= block_count_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.done_res    = done_res_reg;
    assign out_ch.cmd_index   = cmd_index_reg;
    assign out_ch.cmd_arg     = cmd_arg_reg;
    assign out_ch.resp_kind   = resp_kind_reg;
    assign out_ch.pre_wait    = pre_wait_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.card_type   = card_type_reg;
    assign out_ch.block_count = block_count_reg;

    // A completion always leaves the sequencer idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (act == sdi_pkg::ACT_DONE || act == sdi_pkg::ACT_CSD)
        |=> phase_reg == sdi_pkg::PH_IDLE)
        else $error("completion did not return to idle");

    // A response while idle leaves the phase idle
    a_idle_response: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.op == sdi_pkg::OP_RESPONSE && phase_reg == sdi_pkg::PH_IDLE
        |=> phase_reg == sdi_pkg::PH_IDLE && $stable(out_valid_reg) == !$past(out_ch.ready)
            || phase_reg == sdi_pkg::PH_IDLE)
        else $error("response in idle changed the phase");

    // Command results carry no status, type or count
    a_cmd_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_res_reg
        |-> status_reg == sdi_pkg::ST_OK && card_type_reg == sdi_pkg::CARD_UNKNOWN &&
            block_count_reg == '0)
        else $error("command result carries completion fields");

    // Failed completions report no capacity
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_res_reg && status_reg != sdi_pkg::ST_OK
        |-> block_count_reg == '0 && cmd_index_reg == sdi_pkg::CMD_GO_IDLE)
        else $error("failed completion carries a block count");

    // An empty output register never stalls the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty output register");

endmodule
